/* rtl/assert_macros.svh */
// Assertion macros used by the RTL of the site table.
// Depends on nothing; included by packed_allele_site_table.sv, which carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Checks that a condition implies another at the same clock edge.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

`endif

/* rtl/pas_pkg.sv */
// Package of the packed allele site table: function and status codes and
// the base decoder. Depends on nothing.
package pas_pkg;

    typedef logic [1:0] t_func;
    typedef logic [3:0] t_status;

    localparam t_func FUNC_LOAD  = 2'd0;
    localparam t_func FUNC_QUERY = 2'd1;
    localparam t_func FUNC_READ  = 2'd2;

    localparam t_status ST_OK          = 4'd0;
    localparam t_status ST_POS_MISS    = 4'd1;
    localparam t_status ST_CONTIG_MISS = 4'd2;
    localparam t_status ST_BAD_A1      = 4'd3;
    localparam t_status ST_BAD_A2      = 4'd4;
    localparam t_status ST_EQUAL       = 4'd5;
    localparam t_status ST_CONTIG_ORD  = 4'd6;
    localparam t_status ST_POS_ORD     = 4'd7;
    localparam t_status ST_FULL        = 4'd8;
    localparam t_status ST_INDEX       = 4'd9;

    // Returns a valid flag in bit 2 and the base code in bits 1:0.
    function automatic logic [2:0] base_code(input logic [7:0] ch);
        logic [2:0] r;
        unique case (ch)
            8'h41, 8'h61: r = 3'b100;
            8'h43, 8'h63: r = 3'b101;
            8'h47, 8'h67: r = 3'b110;
            8'h54, 8'h74: r = 3'b111;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

endpackage

/* rtl/pas_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module pas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/packed_allele_site_table.sv */
// Top level of the packed allele site table; uses pas_pkg, pas_ram and
// assert_macros.svh.
// One item is taken at a time and gives one result. A load or a query by
// contig first walks the contig list, reading and then checking each entry
// (S_CRD, S_CCHK), up to the match or the end of the list. A load then ends
// in S_LOAD_FIN. A query whose contig is not the last one reads the next
// entry for the end of its sites (S_QEND_RD, S_QEND_CHK). It then walks the
// sites of that contig (S_SRD, S_SCHK) up to the match, a larger position
// or the end. A read by index walks the contig entries (S_RCRD, S_RCCHK) up
// to the first entry past the site or the end of the list. Each item passes
// through S_DONE to its result. The contig list and the site list are
// single-read-port memories. The next item is accepted while a result still waits to be taken.
`include "assert_macros.svh"

module packed_allele_site_table #(
    parameter int MAX_SITES   = 4096,
    parameter int MAX_CONTIGS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pas_pkg::t_func    i_func,
    input  logic [15:0]       i_contig_id,
    input  logic [31:0]       i_position,
    input  logic [7:0]        i_allele1_char,
    input  logic [7:0]        i_allele2_char,
    input  logic [11:0]       i_site_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pas_pkg::t_status  o_status,
    output logic [1:0]        o_allele1,
    output logic [1:0]        o_allele2,
    output logic [15:0]       o_site_contig,
    output logic [31:0]       o_site_position
);
    import pas_pkg::*;

    localparam int SAW = $clog2(MAX_SITES);
    localparam int SCW = $clog2(MAX_SITES + 1);
    localparam int CAW = (MAX_CONTIGS > 1) ? $clog2(MAX_CONTIGS) : 1;
    localparam int CDEPTH = (MAX_CONTIGS > 1) ? MAX_CONTIGS : 2;
    localparam int CCW = $clog2(MAX_CONTIGS + 1);
    localparam int CDW = 16 + SCW;
    localparam int SDW = 36;

    typedef enum logic [3:0] {
        S_IDLE, S_CRD, S_CCHK, S_LOAD_FIN, S_QEND_RD, S_QEND_CHK,
        S_SRD, S_SCHK, S_RCRD, S_RCCHK, S_DONE
    } t_state;

    t_state           r_state;
    t_func            r_func;
    logic [15:0]      r_cid;
    logic [31:0]      r_pos;
    logic [7:0]       r_c1, r_c2;
    logic [11:0]      r_sidx;
    logic [CCW-1:0]   r_k;
    logic             r_fresh;
    logic [SCW-1:0]   r_start, r_end, r_i;
    logic [SCW-1:0]   r_site_count;
    logic [CCW-1:0]   r_contig_count;
    logic [31:0]      r_last_pos;
    t_status          r_st;
    logic [1:0]       r_a1, r_a2;
    logic [15:0]      r_rc;
    logic [31:0]      r_rp;
    logic             r_out_valid;

    logic             c_we, s_we;
    logic [CDW-1:0]   c_wdata, c_rdata;
    logic [SDW-1:0]   s_wdata, s_rdata;
    logic [SAW-1:0]   s_raddr;
    logic [15:0]      c_id;
    logic [SCW-1:0]   c_start;
    logic [2:0]       b1, b2;
    logic [31:0]      sidx_ext;
    t_status          load_st;

    assign c_id     = c_rdata[CDW-1:SCW];
    assign c_start  = c_rdata[SCW-1:0];
    assign b1       = base_code(r_c1);
    assign b2       = base_code(r_c2);
    assign sidx_ext = {20'd0, r_sidx};
    assign s_raddr  = (r_state == S_SRD) ? r_i[SAW-1:0] : SAW'(r_sidx);

    always_comb begin
        priority if (r_site_count >= SCW'(MAX_SITES) ||
                     (r_fresh && r_contig_count >= CCW'(MAX_CONTIGS))) begin
            load_st = ST_FULL;
        end else if (!r_fresh && (r_k + 1'b1) != r_contig_count) begin
            load_st = ST_CONTIG_ORD;
        end else if (!r_fresh && r_site_count != '0 && r_pos < r_last_pos) begin
            load_st = ST_POS_ORD;
        end else if (!b1[2]) begin
            load_st = ST_BAD_A1;
        end else if (!b2[2]) begin
            load_st = ST_BAD_A2;
        end else if (b1[1:0] == b2[1:0]) begin
            load_st = ST_EQUAL;
        end else begin
            load_st = ST_OK;
        end
    end

    assign c_we    = (r_state == S_LOAD_FIN) && (load_st == ST_OK) && r_fresh;
    assign s_we    = (r_state == S_LOAD_FIN) && (load_st == ST_OK);
    assign c_wdata = {r_cid, r_site_count};
    assign s_wdata = {b2[1:0], b1[1:0], r_pos};

    pas_ram #(.WIDTH(CDW), .DEPTH(CDEPTH)) u_contig_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (r_contig_count[CAW-1:0]),
        .i_wdata (c_wdata),
        .i_raddr (r_k[CAW-1:0]),
        .o_rdata (c_rdata)
    );

    pas_ram #(.WIDTH(SDW), .DEPTH(MAX_SITES)) u_site_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_site_count[SAW-1:0]),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_site_count   <= '0;
            r_contig_count <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func  <= i_func;
                        r_cid   <= i_contig_id;
                        r_pos   <= i_position;
                        r_c1    <= i_allele1_char;
                        r_c2    <= i_allele2_char;
                        r_sidx  <= i_site_index;
                        r_k     <= '0;
                        r_fresh <= 1'b1;
                        r_st    <= ST_OK;
                        r_a1    <= '0;
                        r_a2    <= '0;
                        r_rc    <= '0;
                        r_rp    <= '0;
                        if (i_func == FUNC_LOAD || i_func == FUNC_QUERY) begin
                            if (r_contig_count != '0) begin
                                r_state <= S_CRD;
                            end else if (i_func == FUNC_LOAD) begin
                                r_state <= S_LOAD_FIN;
                            end else begin
                                r_st    <= ST_CONTIG_MISS;
                                r_state <= S_DONE;
                            end
                        end else if (i_func == FUNC_READ &&
                                     {20'd0, i_site_index} < 32'(r_site_count)) begin
                            r_state <= S_RCRD;
                        end else begin
                            r_st    <= ST_INDEX;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CRD: r_state <= S_CCHK;
                S_CCHK: begin
                    if (c_id == r_cid) begin
                        r_fresh <= 1'b0;
                        r_start <= c_start;
                        if (r_func == FUNC_LOAD) begin
                            r_state <= S_LOAD_FIN;
                        end else if ((r_k + 1'b1) < r_contig_count) begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_QEND_RD;
                        end else begin
                            r_end   <= r_site_count;
                            r_i     <= c_start;
                            r_state <= S_SRD;
                        end
                    end else if ((r_k + 1'b1) == r_contig_count) begin
                        if (r_func == FUNC_LOAD) begin
                            r_state <= S_LOAD_FIN;
                        end else begin
                            r_st    <= ST_CONTIG_MISS;
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_LOAD_FIN: begin
                    r_st <= load_st;
                    if (load_st == ST_OK) begin
                        r_site_count <= r_site_count + 1'b1;
                        r_last_pos   <= r_pos;
                        if (r_fresh) begin
                            r_contig_count <= r_contig_count + 1'b1;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_QEND_RD: r_state <= S_QEND_CHK;
                S_QEND_CHK: begin
                    r_end   <= c_start;
                    r_i     <= r_start;
                    r_state <= S_SRD;
                end
                S_SRD: begin
                    if (r_i >= r_end) begin
                        r_st    <= ST_POS_MISS;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SCHK;
                    end
                end
                S_SCHK: begin
                    if (s_rdata[31:0] > r_pos) begin
                        r_st    <= ST_POS_MISS;
                        r_state <= S_DONE;
                    end else if (s_rdata[31:0] == r_pos) begin
                        r_a1    <= s_rdata[33:32];
                        r_a2    <= s_rdata[35:34];
                        r_rc    <= r_cid;
                        r_rp    <= r_pos;
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_RCRD: r_state <= S_RCCHK;
                S_RCCHK: begin
                    if (sidx_ext >= 32'(c_start)) begin
                        r_rc <= c_id;
                    end
                    if (sidx_ext >= 32'(c_start) && (r_k + 1'b1) < r_contig_count) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_RCRD;
                    end else begin
                        r_a1    <= s_rdata[33:32];
                        r_a2    <= s_rdata[35:34];
                        r_rp    <= s_rdata[31:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            o_status        <= r_st;
            o_allele1       <= r_a1;
            o_allele2       <= r_a2;
            o_site_contig   <= r_rc;
            o_site_position <= r_rp;
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_ALWAYS(a_site_bound, i_clk, i_rst_n, r_site_count <= SCW'(MAX_SITES))
    `ASSERT_ALWAYS(a_contig_bound, i_clk, i_rst_n, r_contig_count <= CCW'(MAX_CONTIGS))
    `ASSERT_IMPLIES(a_no_orphan_sites, i_clk, i_rst_n, r_contig_count == '0, r_site_count == '0)
endmodule

/* tb/tb_packed_allele_site_table.sv */
// Testbench of the packed allele site table: loads, queries, reads by index and
// the unused function code, checked against a behavioral copy of the table. Depends on pas_pkg and the RTL.
`timescale 1ns / 100ps

module tb_packed_allele_site_table;
    import pas_pkg::*;

    localparam int N_SITES   = 4096;
    localparam int N_CONTIGS = 64;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        t_status     status;
        logic [1:0]  allele1;
        logic [1:0]  allele2;
        logic [15:0] site_contig;
        logic [31:0] site_position;
    } t_site_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_func       i_func = FUNC_LOAD;
    logic [15:0] i_contig_id = '0;
    logic [31:0] i_position = '0;
    logic [7:0]  i_allele1_char = '0;
    logic [7:0]  i_allele2_char = '0;
    logic [11:0] i_site_index = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_status     o_status;
    logic [1:0]  o_allele1;
    logic [1:0]  o_allele2;
    logic [15:0] o_site_contig;
    logic [31:0] o_site_position;

    packed_allele_site_table u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Behavioral copy of the table.
    logic [3:0]  site_codes[N_SITES];
    logic [31:0] site_pos[N_SITES];
    logic [15:0] contig_id_tab[N_CONTIGS];
    int          contig_start_tab[N_CONTIGS];
    int          n_sites;
    int          n_contigs;

    t_site_result expected_results[$];
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  failed;
    longint cycle_count;

    function automatic int base_value(logic [7:0] ch);
        case (ch)
            "A", "a": return 0;
            "C", "c": return 1;
            "G", "g": return 2;
            "T", "t": return 3;
            default: return -1;
        endcase
    endfunction

    function automatic int contig_slot(logic [15:0] id);
        int c;
        c = 0;
        while (c < n_contigs && contig_id_tab[c] != id) c++;
        return c;
    endfunction

    function automatic t_site_result predict_table(t_func fn, logic [15:0] cid,
            logic [31:0] pos, logic [7:0] c1, logic [7:0] c2, logic [11:0] sidx);
        t_site_result r;
        int c;
        int b1;
        int b2;
        int i;
        int stop;
        bit fresh;
        r = '0;
        case (fn)
            FUNC_LOAD: begin
                c = contig_slot(cid);
                fresh = (c >= n_contigs);
                b1 = base_value(c1);
                b2 = base_value(c2);
                if (n_sites >= N_SITES || (fresh && n_contigs >= N_CONTIGS)) r.status = ST_FULL;
                else if (!fresh && c + 1 != n_contigs) r.status = ST_CONTIG_ORD;
                else if (!fresh && pos < site_pos[n_sites-1]) r.status = ST_POS_ORD;
                else if (b1 < 0) r.status = ST_BAD_A1;
                else if (b2 < 0) r.status = ST_BAD_A2;
                else if (b1 == b2) r.status = ST_EQUAL;
                else begin
                    r.status = ST_OK;
                    if (fresh) begin
                        contig_id_tab[n_contigs] = cid;
                        contig_start_tab[n_contigs] = n_sites;
                        n_contigs++;
                    end
                    site_codes[n_sites] = {b2[1:0], b1[1:0]};
                    site_pos[n_sites] = pos;
                    n_sites++;
                end
            end
            FUNC_QUERY: begin
                c = contig_slot(cid);
                if (c >= n_contigs) begin
                    r.status = ST_CONTIG_MISS;
                end else begin
                    i = contig_start_tab[c];
                    stop = (c + 1 < n_contigs) ? contig_start_tab[c+1] : n_sites;
                    while (i < stop && site_pos[i] < pos) i++;
                    if (i < stop && site_pos[i] == pos) begin
                        r.status = ST_OK;
                        r.allele1 = site_codes[i][1:0];
                        r.allele2 = site_codes[i][3:2];
                        r.site_contig = cid;
                        r.site_position = pos;
                    end else begin
                        r.status = ST_POS_MISS;
                    end
                end
            end
            FUNC_READ: begin
                if (int'(sidx) >= n_sites) begin
                    r.status = ST_INDEX;
                end else begin
                    c = 0;
                    while (c + 1 < n_contigs && int'(sidx) >= contig_start_tab[c+1]) c++;
                    r.status = ST_OK;
                    r.allele1 = site_codes[sidx][1:0];
                    r.allele2 = site_codes[sidx][3:2];
                    r.site_contig = contig_id_tab[c];
                    r.site_position = site_pos[sidx];
                end
            end
            default: r.status = ST_INDEX;
        endcase
        return r;
    endfunction

    task automatic send_item(t_func fn, logic [15:0] cid, logic [31:0] pos,
            logic [7:0] c1, logic [7:0] c2, logic [11:0] sidx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= fn;
        i_contig_id <= cid;
        i_position <= pos;
        i_allele1_char <= c1;
        i_allele2_char <= c2;
        i_site_index <= sidx;
        expected_results.push_back(predict_table(fn, cid, pos, c1, c2, sidx));
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_site_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no expectation, status %0d", o_status);
                failed = 1'b1;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, o_status);
                    failed = 1'b1;
                end
                if (o_allele1 !== exp_r.allele1) begin
                    $error("allele1: expected %0d, actual %0d", exp_r.allele1, o_allele1);
                    failed = 1'b1;
                end
                if (o_allele2 !== exp_r.allele2) begin
                    $error("allele2: expected %0d, actual %0d", exp_r.allele2, o_allele2);
                    failed = 1'b1;
                end
                if (o_site_contig !== exp_r.site_contig) begin
                    $error("site_contig: expected %0h, actual %0h",
                           exp_r.site_contig, o_site_contig);
                    failed = 1'b1;
                end
                if (o_site_position !== exp_r.site_position) begin
                    $error("site_position: expected %0h, actual %0h",
                           exp_r.site_position, o_site_position);
                    failed = 1'b1;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] pick_base();
        logic [7:0] bases[8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};
        return bases[$urandom_range(7)];
    endfunction

    function automatic logic [7:0] pick_char();
        if ($urandom_range(9) == 0) return 8'($urandom);
        return pick_base();
    endfunction

    task automatic test_directed();
        send_item(FUNC_QUERY, 16'h0000, 32'h0, 8'h0, 8'h0, 12'd0);
        send_item(FUNC_READ, 16'h0, 32'h0, 8'h0, 8'h0, 12'd0);
        send_item(FUNC_LOAD, 16'hFFFF, 32'h0, "A", "c", 12'hFFF);
        send_item(FUNC_LOAD, 16'hFFFF, 32'hFFFF_FFFF, "g", "T", 12'd0);
        send_item(FUNC_LOAD, 16'hFFFF, 32'hFFFF_FFFF, "C", "G", 12'd0);
        send_item(FUNC_LOAD, 16'hFFFF, 32'h10, "A", "C", 12'd0);
        send_item(FUNC_LOAD, 16'h0000, 32'h5, "N", "C", 12'd0);
        send_item(FUNC_LOAD, 16'h0000, 32'h5, "a", 8'hFF, 12'd0);
        send_item(FUNC_LOAD, 16'h0000, 32'h5, "t", "T", 12'd0);
        send_item(FUNC_LOAD, 16'h0000, 32'h5, "t", "a", 12'd0);
        send_item(FUNC_LOAD, 16'hFFFF, 32'h20, "A", "C", 12'd0);
        send_item(FUNC_QUERY, 16'hFFFF, 32'hFFFF_FFFF, 8'h0, 8'h0, 12'd0);
        send_item(FUNC_QUERY, 16'hFFFF, 32'h1, 8'h0, 8'h0, 12'd0);
        send_item(FUNC_QUERY, 16'h1234, 32'h5, 8'h0, 8'h0, 12'd0);
        send_item(FUNC_QUERY, 16'h0000, 32'h5, 8'h0, 8'h0, 12'd0);
        send_item(FUNC_READ, 16'h0, 32'h0, 8'h0, 8'h0, 12'd2);
        send_item(FUNC_READ, 16'h0, 32'h0, 8'h0, 8'h0, 12'd3);
        send_item(FUNC_READ, 16'h0, 32'h0, 8'h0, 8'h0, 12'hFFF);
        send_item(t_func'(2'd3), 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 12'hFFF);
    endtask

    // Loads mostly well formed rows in rising order, with queries and reads mostly
    // aimed at stored sites, plus a share of broken rows and unused function codes.
    task automatic test_random(int n_items);
        logic [15:0] cid;
        logic [31:0] pos;
        int k;
        int sel;
        for (k = 0; k < n_items; k++) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                if (n_contigs == 0 || $urandom_range(15) == 0) begin
                    cid = 16'($urandom);
                    pos = $urandom_range(1000);
                end else begin
                    cid = contig_id_tab[n_contigs-1];
                    pos = site_pos[n_sites-1] + $urandom_range(3);
                    if ($urandom_range(19) == 0) pos = 32'($urandom);
                    if ($urandom_range(19) == 0) cid = contig_id_tab[$urandom_range(n_contigs-1)];
                end
                send_item(FUNC_LOAD, cid, pos, pick_char(), pick_char(), 12'($urandom));
            end else if (sel < 70) begin
                if (n_sites > 0 && $urandom_range(3) != 0) begin
                    cid = contig_id_tab[$urandom_range(n_contigs-1)];
                    pos = site_pos[$urandom_range(n_sites-1)] + $urandom_range(1);
                end else begin
                    cid = 16'($urandom);
                    pos = $urandom;
                end
                send_item(FUNC_QUERY, cid, pos, 8'($urandom), 8'($urandom), 12'($urandom));
            end else if (sel < 97) begin
                send_item(FUNC_READ, 16'($urandom), $urandom, 8'($urandom), 8'($urandom),
                          (n_sites > 0 && $urandom_range(7) != 0) ?
                          12'($urandom_range(n_sites-1)) : 12'($urandom));
            end else begin
                send_item(t_func'(2'd3), 16'($urandom), $urandom, 8'($urandom),
                          8'($urandom), 12'($urandom));
            end
        end
    endtask

    // Fills the contig list to its limit, checking the full table case.
    task automatic test_fill();
        int k;
        k = 0;
        while (n_contigs < N_CONTIGS) begin
            send_item(FUNC_LOAD, 16'(16'h8000 + k), 32'd7, "G", "C", 12'd0);
            k++;
        end
        send_item(FUNC_LOAD, 16'h7FFE, 32'd7, "G", "C", 12'd0);
        send_item(FUNC_LOAD, 16'h7FFF, 32'd7, "G", "C", 12'd0);
        send_item(FUNC_LOAD, contig_id_tab[n_contigs-1], 32'hFFFF_FFFF, "A", "T", 12'd0);
        send_item(FUNC_READ, 16'h0, 32'h0, 8'h0, 8'h0, 12'hFFF);
        send_item(FUNC_QUERY, contig_id_tab[n_contigs-1], 32'hFFFF_FFFF, 8'h0, 8'h0, 12'd0);
        send_item(FUNC_QUERY, contig_id_tab[0], 32'd7, 8'h0, 8'h0, 12'd0);
        for (k = 0; k < 40; k++)
            send_item(FUNC_READ, 16'h0, 32'h0, 8'h0, 8'h0, 12'($urandom));
    endtask

    initial begin
        int k;
        failed = 1'b0;
        cycle_count = 0;
        n_sites = 0;
        n_contigs = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (k = 0; k < N_SITES; k++) begin
            site_codes[k] = '0;
            site_pos[k] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 23;
        recv_idle_pct = 68;
        test_directed();
        test_random(500);
        send_idle_pct = 68;
        recv_idle_pct = 23;
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500);
        test_fill();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (!failed && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
